// ----- hw/rtl/wea_pkg.sv -----
// ----------------------------------------------------------------------------
// wea_pkg
// Types and constants shared by the weighted edit alignment block.
// ----------------------------------------------------------------------------
package wea_pkg;

    localparam int CMD_BITS  = 2;
    localparam int KIND_BITS = 2;
    localparam int POS_BITS  = 6;
    localparam int COST_BITS = 15;
    localparam int CFG_BITS  = 8;
    localparam int CFG_IDX_BITS = 2;
    localparam int TOKEN_FIELD_BITS = 16;

    localparam logic [CMD_BITS-1:0] CMD_LEX   = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_SURF  = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_ALIGN = 2'd2;

    localparam logic [KIND_BITS-1:0] KIND_MATCH = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_SUB   = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_DEL   = 2'd2;
    localparam logic [KIND_BITS-1:0] KIND_INS   = 2'd3;

    localparam logic [1:0] CH_ORIGIN = 2'd0;
    localparam logic [1:0] CH_DIAG   = 2'd1;
    localparam logic [1:0] CH_UP     = 2'd2;
    localparam logic [1:0] CH_LEFT   = 2'd3;

    localparam logic [CFG_IDX_BITS-1:0] REG_INS = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DEL = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SUB = 2'd2;

    typedef struct packed {
        logic [1:0]                  command;
        logic [TOKEN_FIELD_BITS-1:0] token;
    } in_item_t;

    typedef struct packed {
        logic [KIND_BITS-1:0] step_kind;
        logic [POS_BITS-1:0]  lexical_position;
        logic [POS_BITS-1:0]  surface_position;
        logic [COST_BITS-1:0] total_cost;
        logic                 final_step;
    } out_item_t;

endpackage

// ----- hw/rtl/wea_front.sv -----
// ----------------------------------------------------------------------------
// wea_front
// Input stage: takes items and pushes them into a two-entry queue.
// ----------------------------------------------------------------------------
module wea_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  wea_pkg::in_item_t  in_item,
    output logic               q_valid,
    input  logic               q_pop,
    output wea_pkg::in_item_t  q_item
);
    import wea_pkg::*;

    in_item_t    mem_reg [2];
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg;
    logic        push;

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (q_pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= in_item;
    end

endmodule

// ----- hw/rtl/wea_back.sv -----
// ----------------------------------------------------------------------------
// wea_back
// Execution stage: token stores, grid fill and traceback.
// ----------------------------------------------------------------------------
module wea_back #(
    parameter int MAX_LEN    = 32,
    parameter int TOKEN_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  wea_pkg::in_item_t             q_item,
    input  logic [wea_pkg::CFG_BITS-1:0]  ins_cost,
    input  logic [wea_pkg::CFG_BITS-1:0]  del_cost,
    input  logic [wea_pkg::CFG_BITS-1:0]  sub_cost,
    output logic                          out_valid,
    input  logic                          out_stall,
    output wea_pkg::out_item_t            out_item
);
    import wea_pkg::*;

    localparam int SIDE  = MAX_LEN + 1;
    localparam int CELLS = SIDE * SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int IW    = $clog2(SIDE);
    localparam int LW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int TW    = (TOKEN_BITS < TOKEN_FIELD_BITS) ? TOKEN_BITS : TOKEN_FIELD_BITS;
    localparam int GW    = COST_BITS + 3;
    localparam logic [GW-1:0] SAT = GW'((1 << COST_BITS) - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_F_RD, S_F_WT, S_F_CALC, S_T_RD, S_T_WT, S_T_OUT, S_T_CHK
    } state_t;

    state_t              state_reg;
    logic [TW-1:0]       lex_mem [MAX_LEN];
    logic [TW-1:0]       srf_mem [MAX_LEN];
    logic [1:0]          ch_mem   [CELLS];
    logic [IW-1:0]       lcnt_reg, scnt_reg, n1_reg, n2_reg, i_reg, j_reg;
    logic [GW-1:0]       left_reg, rd_diag_reg, rd_up_reg, total_reg;
    logic [GW-1:0]       row_mem  [SIDE];
    logic [TW-1:0]       lt_reg, st_reg;
    logic [1:0]          ch_rd_reg;
    logic [AW-1:0]       addr;
    logic                valid_reg;
    out_item_t           item_reg;

    logic [GW-1:0]       c_diag, c_left, c_up, best;
    logic [1:0]          ch;
    logic                same;
    logic [IW-1:0]       i_next, j_next;

    assign addr = AW'(i_reg) * AW'(SIDE) + AW'(j_reg);
    assign same = (lt_reg == st_reg);
    assign c_diag = rd_diag_reg + (same ? '0 : GW'({sub_cost, 1'b0}));
    assign c_left = left_reg + GW'(ins_cost);
    assign c_up   = rd_up_reg + GW'(del_cost);

    always_comb
    begin
        best = c_diag;
        ch   = CH_DIAG;
        priority if (i_reg == '0 && j_reg == '0)
        begin
            best = '0;
            ch   = CH_ORIGIN;
        end
        else if (i_reg == '0)
        begin
            best = c_left;
            ch   = CH_LEFT;
        end
        else if (j_reg == '0)
        begin
            best = c_up;
            ch   = CH_UP;
        end
        else
        begin
            if (c_left < best)
            begin
                best = c_left;
                ch   = CH_LEFT;
            end
            if (c_up < best)
            begin
                best = c_up;
                ch   = CH_UP;
            end
        end
    end

    assign q_pop     = q_valid && (state_reg == S_IDLE) && !(valid_reg && out_stall);
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        i_next = i_reg;
        j_next = j_reg;
        unique case (ch_rd_reg)
            CH_DIAG:
            begin
                i_next = i_reg - 1'b1;
                j_next = j_reg - 1'b1;
            end
            CH_UP:   i_next = i_reg - 1'b1;
            default: j_next = j_reg - 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
            lcnt_reg  <= '0;
            scnt_reg  <= '0;
            n1_reg    <= '0;
            n2_reg    <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            if (state_reg == S_T_OUT && !(valid_reg && out_stall))
                valid_reg <= 1'b1;
            else if (valid_reg && !out_stall)
                valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        priority case (q_item.command)
                            CMD_LEX:
                                if (lcnt_reg < IW'(MAX_LEN))
                                    lcnt_reg <= lcnt_reg + 1'b1;
                            CMD_SURF:
                                if (scnt_reg < IW'(MAX_LEN))
                                    scnt_reg <= scnt_reg + 1'b1;
                            CMD_ALIGN:
                            begin
                                lcnt_reg <= '0;
                                scnt_reg <= '0;
                                n1_reg   <= lcnt_reg;
                                n2_reg   <= scnt_reg;
                                i_reg    <= '0;
                                j_reg    <= '0;
                                if (lcnt_reg != '0 || scnt_reg != '0)
                                    state_reg <= S_F_RD;
                            end
                            default: ;
                        endcase
                    end
                end
                S_F_RD:   state_reg <= S_F_WT;
                S_F_WT:   state_reg <= S_F_CALC;
                S_F_CALC:
                begin
                    if (j_reg == n2_reg)
                    begin
                        if (i_reg == n1_reg)
                            state_reg <= S_T_RD;
                        else
                        begin
                            i_reg     <= i_reg + 1'b1;
                            j_reg     <= '0;
                            state_reg <= S_F_RD;
                        end
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_F_RD;
                    end
                end
                S_T_RD:   state_reg <= S_T_WT;
                S_T_WT:   state_reg <= S_T_OUT;
                S_T_OUT:
                begin
                    if (!(valid_reg && out_stall))
                    begin
                        i_reg     <= i_next;
                        j_reg     <= j_next;
                        state_reg <= S_T_CHK;
                    end
                end
                default:
                begin
                    if (i_reg == '0 && j_reg == '0)
                        state_reg <= S_IDLE;
                    else
                        state_reg <= S_T_RD;
                end
            endcase
        end
    end

    // Token stores, choice grid and row buffer of the row above
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && q_pop)
        begin
            if (q_item.command == CMD_LEX && lcnt_reg < IW'(MAX_LEN))
                lex_mem[lcnt_reg[LW-1:0]] <= q_item.token[TW-1:0];
            if (q_item.command == CMD_SURF && scnt_reg < IW'(MAX_LEN))
                srf_mem[scnt_reg[LW-1:0]] <= q_item.token[TW-1:0];
        end
        if (state_reg == S_F_RD || state_reg == S_T_RD)
        begin
            lt_reg    <= lex_mem[LW'(i_reg - 1'b1)];
            st_reg    <= srf_mem[LW'(j_reg - 1'b1)];
            rd_up_reg <= row_mem[j_reg];
            rd_diag_reg <= row_mem[IW'(j_reg - 1'b1)];
            ch_rd_reg <= ch_mem[addr];
        end
        if (state_reg == S_F_CALC)
        begin
            ch_mem[addr]   <= ch;
            left_reg       <= best;
            if (j_reg != '0)
                row_mem[IW'(j_reg - 1'b1)] <= left_reg;
            if (j_reg == n2_reg)
                row_mem[j_reg] <= best;
            if (i_reg == n1_reg && j_reg == n2_reg)
                total_reg <= (best > SAT) ? SAT : best;
        end
        if (state_reg == S_T_OUT && !(valid_reg && out_stall))
        begin
            item_reg.total_cost <= total_reg[COST_BITS-1:0];
            item_reg.final_step <= (i_next == '0 && j_next == '0);
            unique case (ch_rd_reg)
                CH_DIAG:
                begin
                    item_reg.step_kind        <= same ? KIND_MATCH : KIND_SUB;
                    item_reg.lexical_position <= POS_BITS'(i_reg);
                    item_reg.surface_position <= POS_BITS'(j_reg);
                end
                CH_UP:
                begin
                    item_reg.step_kind        <= KIND_DEL;
                    item_reg.lexical_position <= POS_BITS'(i_reg);
                    item_reg.surface_position <= '0;
                end
                default:
                begin
                    item_reg.step_kind        <= KIND_INS;
                    item_reg.lexical_position <= '0;
                    item_reg.surface_position <= POS_BITS'(j_reg);
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/weighted_edit_alignment.sv -----
// ----------------------------------------------------------------------------
// weighted_edit_alignment
// Weighted edit-distance aligner with traceback.
// ----------------------------------------------------------------------------
// Append commands are taken at one per cycle through a two-entry queue; while
// an align runs the queue fills and the input stalls. An align command fills the
// (n1+1)*(n2+1) cost grid cell by cell (read, wait, calc) through the single-port
// grid memory, then traces back step by step (read, wait, output, check; held
// by output stalls). Results come out last step first; the final step is marked.
module weighted_edit_alignment #(
    parameter int MAX_LEN    = 32,
    parameter int TOKEN_BITS = 16
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  wea_pkg::in_item_t                     in_item,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output wea_pkg::out_item_t                    out_item,
    input  logic                                  cfg_we,
    input  logic [wea_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [wea_pkg::CFG_BITS-1:0]          cfg_data
);
    import wea_pkg::*;

    logic [CFG_BITS-1:0] ins_reg, del_reg, sub_reg;
    logic                q_valid, q_pop;
    in_item_t            q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ins_reg <= CFG_BITS'(1);
            del_reg <= CFG_BITS'(1);
            sub_reg <= CFG_BITS'(1);
        end
        else if (cfg_we)
        begin
            priority case (cfg_index)
                REG_INS: ins_reg <= cfg_data;
                REG_DEL: del_reg <= cfg_data;
                REG_SUB: sub_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    wea_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_item (in_item),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_item  (q_item)
    );

    wea_back #(
        .MAX_LEN   (MAX_LEN),
        .TOKEN_BITS(TOKEN_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item),
        .ins_cost (ins_reg),
        .del_cost (del_reg),
        .sub_cost (sub_reg),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item (out_item)
    );

endmodule

// ----- sim/weighted_edit_alignment_tb.sv -----
// ----------------------------------------------------------------------------
// weighted_edit_alignment_tb
// Self-checking bench for the weighted edit alignment block. Token sequences
// and align commands are sent through the input channel. A cycle-free
// predictor fills its own cost grid and traces back to build the expected
// steps, which are compared as whole items against the output items. Cost
// registers are changed between phases, and idle and stall patterns vary.
// ----------------------------------------------------------------------------
module weighted_edit_alignment_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import wea_pkg::*;

    localparam int MAX_LEN     = 32;
    localparam int SIDE        = MAX_LEN + 1;
    localparam int SETTLE_WAIT = 3600;
    localparam int WATCHDOG    = 20000;
    localparam logic [CMD_BITS-1:0] CMD_NONE = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_item;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_item;
    logic        cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0]     cfg_data;

    weighted_edit_alignment DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    int          ins_cost;
    int          del_cost;
    int          sub_cost;
    logic [15:0] lex_tokens[$];
    logic [15:0] surf_tokens[$];
    out_item_t   expected_steps[$];

    int send_gap_pct;
    int stall_pct;
    int hold_left;
    int mismatches;
    int items_sent;
    int steps_seen;
    int aligns_done;
    int idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void predict_alignment();
        int          cost[SIDE][SIDE];
        logic [1:0]  choice[SIDE][SIDE];
        int          n1;
        int          n2;
        int          i;
        int          j;
        int          c;
        int          total;
        out_item_t   step;
        n1 = lex_tokens.size();
        n2 = surf_tokens.size();
        if (n1 == 0 && n2 == 0)
            return;
        for (i = 0; i <= n1; i++)
        begin
            for (j = 0; j <= n2; j++)
            begin
                if (i == 0 && j == 0)
                begin
                    cost[i][j] = 0;
                    choice[i][j] = CH_ORIGIN;
                end
                else if (i == 0)
                begin
                    cost[i][j] = cost[i][j-1] + ins_cost;
                    choice[i][j] = CH_LEFT;
                end
                else if (j == 0)
                begin
                    cost[i][j] = cost[i-1][j] + del_cost;
                    choice[i][j] = CH_UP;
                end
                else
                begin
                    cost[i][j] = cost[i-1][j-1] +
                        ((lex_tokens[i-1] == surf_tokens[j-1]) ? 0 : 2 * sub_cost);
                    choice[i][j] = CH_DIAG;
                    c = cost[i][j-1] + ins_cost;
                    if (c < cost[i][j])
                    begin
                        cost[i][j] = c;
                        choice[i][j] = CH_LEFT;
                    end
                    c = cost[i-1][j] + del_cost;
                    if (c < cost[i][j])
                    begin
                        cost[i][j] = c;
                        choice[i][j] = CH_UP;
                    end
                end
            end
        end
        total = (cost[n1][n2] > 32767) ? 32767 : cost[n1][n2];
        i = n1;
        j = n2;
        while (i != 0 || j != 0)
        begin
            step.total_cost = total[COST_BITS-1:0];
            if (choice[i][j] == CH_DIAG)
            begin
                step.step_kind = (lex_tokens[i-1] == surf_tokens[j-1]) ? KIND_MATCH
                                                                       : KIND_SUB;
                step.lexical_position = i[POS_BITS-1:0];
                step.surface_position = j[POS_BITS-1:0];
                i--;
                j--;
            end
            else if (choice[i][j] == CH_UP)
            begin
                step.step_kind = KIND_DEL;
                step.lexical_position = i[POS_BITS-1:0];
                step.surface_position = '0;
                i--;
            end
            else
            begin
                step.step_kind = KIND_INS;
                step.lexical_position = '0;
                step.surface_position = j[POS_BITS-1:0];
                j--;
            end
            step.final_step = (i == 0 && j == 0);
            expected_steps.push_back(step);
        end
    endfunction

    function automatic void predict_item(logic [1:0] cmd, logic [15:0] tok);
        if (cmd == CMD_LEX)
        begin
            if (lex_tokens.size() < MAX_LEN)
                lex_tokens.push_back(tok);
        end
        else if (cmd == CMD_SURF)
        begin
            if (surf_tokens.size() < MAX_LEN)
                surf_tokens.push_back(tok);
        end
        else if (cmd == CMD_ALIGN)
        begin
            predict_alignment();
            lex_tokens.delete();
            surf_tokens.delete();
            aligns_done++;
        end
    endfunction

    task automatic send_item(logic [1:0] cmd, logic [15:0] tok);
        int gap;
        if ($urandom_range(0, 99) < send_gap_pct)
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item.command <= cmd;
        in_item.token <= tok;
        do
            @(posedge clk);
        while (in_stall);
        predict_item(cmd, tok);
        items_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (expected_steps.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_costs(int ins, int del, int sub);
        cfg_we <= 1'b1;
        cfg_index <= REG_INS;
        cfg_data <= ins[7:0];
        @(posedge clk);
        cfg_index <= REG_DEL;
        cfg_data <= del[7:0];
        @(posedge clk);
        cfg_index <= REG_SUB;
        cfg_data <= sub[7:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        ins_cost = ins;
        del_cost = del;
        sub_cost = sub;
    endtask

    task automatic send_pair(int n_lex, int n_surf, bit wide_tokens);
        int          lex_left;
        int          surf_left;
        logic [15:0] tok;
        lex_left = n_lex;
        surf_left = n_surf;
        while (lex_left + surf_left > 0)
        begin
            tok = wide_tokens ? 16'($urandom()) : 16'($urandom_range(0, 3));
            if (surf_left == 0 || (lex_left > 0 && $urandom_range(0, 1) == 0))
            begin
                send_item(CMD_LEX, tok);
                lex_left--;
            end
            else
            begin
                send_item(CMD_SURF, tok);
                surf_left--;
            end
        end
        send_item(CMD_ALIGN, 16'($urandom()));
    endtask

    task automatic test_directed();
        send_item(CMD_ALIGN, 16'h0000);
        send_item(CMD_LEX, 16'h0000);
        send_item(CMD_LEX, 16'hFFFF);
        send_item(CMD_ALIGN, 16'hFFFF);
        send_item(CMD_SURF, 16'hFFFF);
        send_item(CMD_SURF, 16'h0000);
        send_item(CMD_ALIGN, 16'h0000);
        send_item(CMD_LEX, 16'hA5A5);
        send_item(CMD_LEX, 16'h0001);
        send_item(CMD_LEX, 16'hFFFF);
        send_item(CMD_NONE, 16'hFFFF);
        send_item(CMD_SURF, 16'hA5A5);
        send_item(CMD_SURF, 16'h0002);
        send_item(CMD_SURF, 16'hFFFF);
        send_item(CMD_SURF, 16'h5A5A);
        send_item(CMD_ALIGN, 16'h5A5A);
        settle();
    endtask

    task automatic test_cost_extremes();
        write_costs(0, 0, 0);
        send_pair(3, 4, 1'b0);
        settle();
        write_costs(255, 255, 255);
        send_pair(MAX_LEN, MAX_LEN, 1'b1);
        send_pair(2, 3, 1'b0);
        settle();
        write_costs(255, 1, 0);
        send_pair(4, 2, 1'b0);
        settle();
        write_costs(1, 200, 128);
        send_pair(3, 5, 1'b0);
        settle();
    endtask

    task automatic test_random(int n_items, int gap_pct, int stl_pct);
        int target;
        send_gap_pct = gap_pct;
        stall_pct = stl_pct;
        target = items_sent + n_items;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 14) == 0)
                send_item(CMD_NONE, 16'($urandom()));
            if ($urandom_range(0, 24) == 0)
                send_pair($urandom_range(MAX_LEN, MAX_LEN + 2),
                          $urandom_range(0, 3), 1'b1);
            else
                send_pair($urandom_range(0, 6), $urandom_range(0, 6),
                          $urandom_range(0, 3) == 0);
        end
        settle();
        write_costs($urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 255));
    endtask

    task automatic test_backpressure();
        int k;
        send_gap_pct = 0;
        stall_pct = 0;
        @(posedge clk);
        hold_left = 400;
        send_pair(6, 6, 1'b0);
        for (k = 0; k < 3; k++)
            send_pair(2, 2, 1'b0);
        settle();
    endtask

    // result checking and receiver stalls
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            steps_seen++;
            if (expected_steps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected step: %p", out_item);
            end
            else
            begin
                if (out_item !== expected_steps[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("step mismatch: expected %p, got %p",
                                 expected_steps[0], out_item);
                end
                void'(expected_steps.pop_front());
            end
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_INS;
        cfg_data = '0;
        ins_cost = 1;
        del_cost = 1;
        sub_cost = 1;
        send_gap_pct = 0;
        stall_pct = 0;
        hold_left = 0;
        mismatches = 0;
        items_sent = 0;
        steps_seen = 0;
        aligns_done = 0;
        idle_cycles = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_cost_extremes();
        test_backpressure();
        test_random(30, 0, 0);
        test_random(30, 55, 0);
        test_random(30, 0, 55);
        test_random(30, 7, 7);

        if (expected_steps.size() != 0)
            mismatches++;
        $display("Sent %0d items in %0d aligns, checked %0d steps, %0d mismatches.",
                 items_sent, aligns_done, steps_seen, mismatches);
        $display("Covered empty, one-sided, full and overfull sequences at extreme costs.");
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
